// File: rtl/dipr_pkg.sv
// shared constants and codes of the replacement policy engine
package dipr_pkg;

    localparam int SETS_DEF          = 2048;
    localparam int WAYS_DEF          = 16;
    localparam int LEADERS_DEF       = 32;
    localparam int SELECTOR_BITS_DEF = 10;

    localparam int LEAD_LIP_MUL = 41;
    localparam int LEAD_BIP_MUL = 67;
    localparam int LEAD_BIP_ADD = 17;

    localparam int BIM_W   = 5;
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int ADDR_W  = 64;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [1:0] CNT_MAX  = 2'd3;

    localparam logic [1:0]  STREAM_TH_RST = 2'd2;
    localparam logic [1:0]  DEAD_TH_RST   = 2'd2;
    localparam logic [15:0] STRIDE_RST    = 16'd1024;
    localparam logic [31:0] DECAY_RST     = 32'd100000;

    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [2:0] OUT_QUERY   = 3'd0;
    localparam logic [2:0] OUT_HIT     = 3'd1;
    localparam logic [2:0] OUT_NEAR    = 3'd2;
    localparam logic [2:0] OUT_DISTANT = 3'd3;
    localparam logic [2:0] OUT_BYPASS  = 3'd4;

    localparam logic [1:0] KIND_FOLLOW = 2'd0;
    localparam logic [1:0] KIND_LIP    = 2'd1;
    localparam logic [1:0] KIND_BIP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd3;

endpackage

// File: rtl/dipr_if.sv
// request and response channel interfaces
interface dipr_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [63:0] address;
    logic        hit;

    modport source (output valid, func, set_index, way, address, hit, input ready);
    modport sink (input valid, func, set_index, way, address, hit, output ready);
endinterface

interface dipr_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic [2:0] outcome;

    modport source (output valid, victim_way, outcome, input ready);
    modport sink (input valid, victim_way, outcome, output ready);
endinterface

// File: rtl/dipr_ram.sv
// generic single write, single read ram with registered read
module dipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/dip_rrip_stream_dead_bypass_policy_core.sv
// top level of the rrip replacement policy engine with stream and dead-block bypass
//
// channel  dir  payload                              request when
// req      in   func set_index way address hit       valid & ready
// rsp      out  victim_way outcome                   valid & ready
// cfg      in   cfg_index cfg_data                   cfg_we
//
// a request first reads its set row, then computes and writes the row back
// all per-set state sits in one ram row; the ram read is registered
// after reset a clearing pass writes every row before the first request is taken
// an inserting update at a decay point starts a sweep that decrements the dead counters of every row
// a pending response blocks write back until taken; req is held off meanwhile
module dip_rrip_stream_dead_bypass_policy_core #(
    parameter int SETS          = dipr_pkg::SETS_DEF,
    parameter int WAYS          = dipr_pkg::WAYS_DEF,
    parameter int LEADERS       = dipr_pkg::LEADERS_DEF,
    parameter int SELECTOR_BITS = dipr_pkg::SELECTOR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    dipr_req_if.sink                       req,
    dipr_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [dipr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dipr_pkg::CFG_W-1:0]     cfg_data
);
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;

    typedef struct packed {
        logic [63:0]           prev_address;
        logic [1:0]            stream_level;
        logic [1:0]            kind;
        logic [WAYS-1:0]       valid;
        logic [WAYS-1:0][1:0]  rrpv;
        logic [WAYS-1:0][1:0]  dead;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [SET_W:0]   ptr_reg, ptr_next;
    logic             swp_wv_reg, swp_wv_next;
    logic [SET_W-1:0] swp_wa_reg, swp_wa_next;

    logic             func_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [63:0]      addr_reg, addr_next;
    logic             hit_reg;

    logic [1:0]  stream_th_reg;
    logic [1:0]  dead_th_reg;
    logic [15:0] stride_reg;
    logic [31:0] period_reg;

    logic [SELECTOR_BITS-1:0] duel_reg, duel_next;
    logic [dipr_pkg::BIM_W-1:0] bim_reg, bim_next;
    logic [31:0] decay_reg, decay_next;

    logic       rsp_valid_reg;
    logic [3:0] victim_reg;
    logic [2:0] outcome_reg;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;

    logic accept, out_free, exec_go;
    logic [SET_W-1:0] set_in;
    logic [WAY_W-1:0] way_in;
    logic [1:0] clr_kind;
    logic [LEADERS-1:0] lip_hit, bip_hit;

    row_t row_rd, row_wr, row_swp, row_clr;
    logic [WAY_W-1:0] victim;
    logic [2:0] outcome;
    logic sweep_go;

    function automatic logic [SET_W-1:0] set_fold(input logic [10:0] v);
        logic [11:0] t;
        t = {1'b0, v};
        for (int k = 5; k >= 0; k--)
        begin
            if ((SETS << k) <= 2047 && t >= 12'(SETS << k))
            begin
                t = t - 12'(SETS << k);
            end
        end
        return SET_W'(t);
    endfunction

    function automatic logic [WAY_W-1:0] way_fold(input logic [3:0] v);
        logic [4:0] t;
        t = {1'b0, v};
        for (int k = 3; k >= 0; k--)
        begin
            if ((WAYS << k) <= 15 && t >= 5'(WAYS << k))
            begin
                t = t - 5'(WAYS << k);
            end
        end
        return WAY_W'(t);
    endfunction

    dipr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // leader pattern for the row being cleared
    for (genvar g = 0; g < LEADERS; g++)
    begin : g_lead
        localparam int LA = (g * dipr_pkg::LEAD_LIP_MUL) % SETS;
        localparam int LB = (g * dipr_pkg::LEAD_BIP_MUL + dipr_pkg::LEAD_BIP_ADD) % SETS;
        assign lip_hit[g] = ptr_reg[SET_W-1:0] == SET_W'(LA);
        assign bip_hit[g] = ptr_reg[SET_W-1:0] == SET_W'(LB);
    end

    always_comb
    begin
        logic found;
        found    = 1'b0;
        clr_kind = dipr_pkg::KIND_FOLLOW;
        for (int g = 0; g < LEADERS; g++)
        begin
            if (!found && (lip_hit[g] || bip_hit[g]))
            begin
                clr_kind = lip_hit[g] ? dipr_pkg::KIND_LIP : dipr_pkg::KIND_BIP;
                found    = 1'b1;
            end
        end
    end

    always_comb
    begin
        row_clr            = '0;
        row_clr.rrpv       = {WAYS{dipr_pkg::RRPV_MAX}};
        row_clr.kind       = clr_kind;
    end

    assign req.ready = state_reg == ST_IDLE;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign exec_go   = state_reg == ST_EXEC && out_free;
    assign set_in    = set_fold(req.set_index);
    assign way_in    = way_fold(req.way);
    assign row_rd    = row_t'(ram_rdata);

    // decay sweep row
    always_comb
    begin
        row_swp = row_rd;
        for (int i = 0; i < WAYS; i++)
        begin
            if (row_rd.dead[i] != 2'd0)
            begin
                row_swp.dead[i] = row_rd.dead[i] - 2'd1;
            end
        end
    end

    // request execution on the row read
    always_comb
    begin
        logic [3:0]      has;
        logic [1:0]      top;
        logic [1:0]      age;
        logic [WAYS-1:0] mask;
        logic [WAY_W-1:0] first, last;
        logic            any, streaming, stride, use_lip, due;
        logic [2:0]      sum;
        logic [63:0]     delta;
        logic [32:0]     dcnt;
        logic [1:0]      dv;
        logic [1:0]      rr;

        row_wr     = row_rd;
        victim     = '0;
        outcome    = dipr_pkg::OUT_QUERY;
        duel_next  = duel_reg;
        bim_next   = bim_reg;
        decay_next = decay_reg;
        sweep_go   = 1'b0;
        has        = '0;
        mask       = '0;
        first      = '0;
        last       = '0;
        stride     = 1'b0;
        use_lip    = 1'b1;
        rr         = dipr_pkg::RRPV_MAX;
        dv         = '0;
        sum        = '0;

        for (int i = 0; i < WAYS; i++)
        begin
            if (row_rd.valid[i])
            begin
                has[row_rd.rrpv[i]] = 1'b1;
            end
        end
        any = |row_rd.valid;
        if (has[3])
        begin
            top = 2'd3;
        end
        else if (has[2])
        begin
            top = 2'd2;
        end
        else if (has[1])
        begin
            top = 2'd1;
        end
        else
        begin
            top = 2'd0;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            mask[i] = row_rd.valid[i] && row_rd.rrpv[i] == top;
        end
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                first = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (mask[i])
            begin
                last = WAY_W'(i);
            end
        end
        age       = dipr_pkg::RRPV_MAX - top;
        streaming = row_rd.stream_level >= stream_th_reg;

        dcnt  = {1'b0, decay_reg} + 33'd1;
        due   = dcnt >= {1'b0, period_reg};
        delta = addr_reg - row_rd.prev_address;

        if (func_reg == dipr_pkg::FUNC_QUERY)
        begin
            if (any)
            begin
                if (streaming)
                begin
                    victim = last;
                end
                else
                begin
                    victim = first;
                    for (int i = 0; i < WAYS; i++)
                    begin
                        sum = {1'b0, row_rd.rrpv[i]} + {1'b0, age};
                        row_wr.rrpv[i] = sum > 3'd3 ? dipr_pkg::RRPV_MAX : sum[1:0];
                    end
                end
            end
        end
        else
        begin
            decay_next = due ? 32'd0 : dcnt[31:0];
            if (row_rd.prev_address != 64'd0)
            begin
                stride = delta != 64'd0 && delta[63:16] == 48'd0
                         && delta[15:0] < stride_reg;
                if (stride)
                begin
                    if (row_rd.stream_level < dipr_pkg::CNT_MAX)
                    begin
                        row_wr.stream_level = row_rd.stream_level + 2'd1;
                    end
                end
                else if (row_rd.stream_level != 2'd0)
                begin
                    row_wr.stream_level = row_rd.stream_level - 2'd1;
                end
            end
            row_wr.prev_address = addr_reg;

            if (hit_reg)
            begin
                row_wr.dead[way_reg]  = 2'd0;
                row_wr.rrpv[way_reg]  = 2'd0;
                row_wr.valid[way_reg] = 1'b1;
                outcome = dipr_pkg::OUT_HIT;
            end
            else
            begin
                dv = row_rd.dead[way_reg];
                if (row_rd.valid[way_reg] && dv < dipr_pkg::CNT_MAX)
                begin
                    dv = dv + 2'd1;
                end
                if (row_wr.stream_level >= stream_th_reg || dv >= dead_th_reg)
                begin
                    row_wr.valid[way_reg] = 1'b0;
                    row_wr.rrpv[way_reg]  = dipr_pkg::RRPV_MAX;
                    row_wr.dead[way_reg]  = 2'd0;
                    outcome = dipr_pkg::OUT_BYPASS;
                end
                else
                begin
                    case (row_rd.kind)
                        dipr_pkg::KIND_LIP: use_lip = 1'b1;
                        dipr_pkg::KIND_BIP: use_lip = 1'b0;
                        default:            use_lip = duel_reg < SEL_HALF;
                    endcase
                    if (!use_lip)
                    begin
                        if (bim_reg == '0)
                        begin
                            rr = 2'd0;
                        end
                        bim_next = bim_reg + 1'b1;
                    end
                    row_wr.valid[way_reg] = 1'b1;
                    row_wr.dead[way_reg]  = 2'd0;
                    row_wr.rrpv[way_reg]  = rr;
                    case (row_rd.kind)
                        dipr_pkg::KIND_LIP:
                        begin
                            if (duel_reg < SEL_MAX)
                            begin
                                duel_next = duel_reg + 1'b1;
                            end
                        end
                        dipr_pkg::KIND_BIP:
                        begin
                            if (duel_reg != '0)
                            begin
                                duel_next = duel_reg - 1'b1;
                            end
                        end
                        default: duel_next = duel_reg;
                    endcase
                    sweep_go = due;
                    outcome  = rr == 2'd0 ? dipr_pkg::OUT_NEAR : dipr_pkg::OUT_DISTANT;
                end
            end
        end
    end

    // sequencing and ram port control
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        swp_wv_next = 1'b0;
        swp_wa_next = swp_wa_reg;
        ram_we      = 1'b0;
        ram_waddr   = set_reg;
        ram_wdata   = row_wr;
        ram_re      = 1'b0;
        ram_raddr   = set_in;
        addr_next   = accept ? req.address : addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[SET_W-1:0];
                ram_wdata = row_clr;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == (SET_W + 1)'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_re = accept;
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    ram_we   = 1'b1;
                    ptr_next = '0;
                    state_next = sweep_go ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                ram_we    = swp_wv_reg;
                ram_waddr = swp_wa_reg;
                ram_wdata = row_swp;
                if (ptr_reg < (SET_W + 1)'(SETS))
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = ptr_reg[SET_W-1:0];
                    swp_wv_next = 1'b1;
                    swp_wa_next = ptr_reg[SET_W-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                else if (!swp_wv_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            swp_wv_reg    <= 1'b0;
            duel_reg      <= SEL_HALF;
            bim_reg       <= '0;
            decay_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            stream_th_reg <= dipr_pkg::STREAM_TH_RST;
            dead_th_reg   <= dipr_pkg::DEAD_TH_RST;
            stride_reg    <= dipr_pkg::STRIDE_RST;
            period_reg    <= dipr_pkg::DECAY_RST;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            swp_wv_reg <= swp_wv_next;
            if (exec_go)
            begin
                duel_reg      <= duel_next;
                bim_reg       <= bim_next;
                decay_reg     <= decay_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    dipr_pkg::CFG_STREAM_TH: stream_th_reg <= cfg_data[1:0];
                    dipr_pkg::CFG_DEAD_TH:   dead_th_reg   <= cfg_data[1:0];
                    dipr_pkg::CFG_STRIDE:    stride_reg    <= cfg_data[15:0];
                    dipr_pkg::CFG_DECAY:     period_reg    <= cfg_data;
                    default:                 period_reg    <= period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        swp_wa_reg <= swp_wa_next;
        addr_reg   <= addr_next;
        if (accept)
        begin
            func_reg <= req.func;
            set_reg  <= set_in;
            way_reg  <= way_in;
            hit_reg  <= req.hit;
        end
        if (exec_go)
        begin
            victim_reg  <= 4'(victim);
            outcome_reg <= outcome;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.victim_way = victim_reg;
    assign rsp.outcome    = outcome_reg;
endmodule

// File: rtl/dipr_checker.sv
// port-level checks of the policy engine, bound to the top level
module dipr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [3:0] rsp_victim_way,
    input logic [2:0] rsp_outcome
);
    // response held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // only defined outcome codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_outcome <= dipr_pkg::OUT_BYPASS)
        else $error("undefined outcome code");

    // one request in flight: ready drops after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // update responses carry way zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_outcome != dipr_pkg::OUT_QUERY |-> rsp_victim_way == 4'd0)
        else $error("update response with nonzero way");
endmodule

bind dip_rrip_stream_dead_bypass_policy_core dipr_checker u_dipr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_victim_way (rsp.victim_way),
    .rsp_outcome    (rsp.outcome)
);

// File: verif/tb_dip_rrip_stream_dead_bypass_policy_core.sv
// testbench of the policy engine: directed table plus random requests, checked by a predictor
`timescale 1ns / 100ps

module tb_dip_rrip_stream_dead_bypass_policy_core;

    localparam int NSETS   = dipr_pkg::SETS_DEF;
    localparam int NWAYS   = dipr_pkg::WAYS_DEF;
    localparam int SEL_MAX = (1 << dipr_pkg::SELECTOR_BITS_DEF) - 1;
    localparam int SEL_HALF = SEL_MAX / 2;
    localparam int DRAIN_CYCLES = NSETS + 150;

    typedef struct packed {
        logic        func;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic [63:0] address;
        logic        hit;
    } access_t;

    typedef struct {
        logic [3:0] victim_way;
        logic [2:0] outcome;
        bit         typed;
        logic [3:0] typed_way;
        logic [2:0] typed_outcome;
    } answer_t;

    typedef struct {
        bit                             is_cfg;
        logic [dipr_pkg::CFG_IDX_W-1:0] idx;
        logic [dipr_pkg::CFG_W-1:0]     data;
        access_t                        acc;
        bit                             typed;
        logic [3:0]                     typed_way;
        logic [2:0]                     typed_outcome;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dipr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dipr_pkg::CFG_W-1:0] cfg_data;

    dipr_req_if req ();
    dipr_rsp_if rsp ();

    dip_rrip_stream_dead_bypass_policy_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    bit          m_valid [0:NSETS*NWAYS-1];
    logic [1:0]  m_rrpv [0:NSETS*NWAYS-1];
    logic [1:0]  m_dead [0:NSETS*NWAYS-1];
    logic [1:0]  m_kind [0:NSETS-1];
    logic [63:0] m_last [0:NSETS-1];
    logic [1:0]  m_stream [0:NSETS-1];
    int          m_sel;
    logic [4:0]  m_bim;
    logic [31:0] m_decay;
    logic [1:0]  m_stream_th;
    logic [1:0]  m_dead_th;
    logic [15:0] m_stride;
    logic [31:0] m_period;

    answer_t answer_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;

    function automatic void policy_reset();
        int a;
        int b;
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            m_valid[i] = 0;
            m_rrpv[i] = dipr_pkg::RRPV_MAX;
            m_dead[i] = 2'd0;
        end
        for (int s = 0; s < NSETS; s++)
        begin
            m_kind[s] = dipr_pkg::KIND_FOLLOW;
            m_last[s] = '0;
            m_stream[s] = 2'd0;
        end
        for (int i = 0; i < dipr_pkg::LEADERS_DEF; i++)
        begin
            a = (i * dipr_pkg::LEAD_LIP_MUL) % NSETS;
            b = (i * dipr_pkg::LEAD_BIP_MUL + dipr_pkg::LEAD_BIP_ADD) % NSETS;
            if (m_kind[a] == dipr_pkg::KIND_FOLLOW) m_kind[a] = dipr_pkg::KIND_LIP;
            if (m_kind[b] == dipr_pkg::KIND_FOLLOW) m_kind[b] = dipr_pkg::KIND_BIP;
        end
        m_sel = SEL_HALF;
        m_bim = 5'd0;
        m_decay = 32'd0;
        m_stream_th = dipr_pkg::STREAM_TH_RST;
        m_dead_th = dipr_pkg::DEAD_TH_RST;
        m_stride = dipr_pkg::STRIDE_RST;
        m_period = dipr_pkg::DECAY_RST;
    endfunction

    function automatic logic [3:0] choose_victim(int base, bit streaming);
        logic [3:0] best;
        logic [1:0] top;
        bit any;
        int r;
        best = 4'd0;
        top = 2'd0;
        any = 0;
        for (int w = 0; w < NWAYS; w++)
        begin
            if (m_valid[base+w] && (!any || m_rrpv[base+w] >= top))
            begin
                top = m_rrpv[base+w];
                best = 4'(w);
            end
            if (m_valid[base+w]) any = 1;
        end
        if (!any) return 4'd0;
        if (streaming) return best;
        for (int w = 0; w < NWAYS; w++)
        begin
            r = m_rrpv[base+w] + (dipr_pkg::RRPV_MAX - top);
            m_rrpv[base+w] = (r > dipr_pkg::RRPV_MAX) ? dipr_pkg::RRPV_MAX : r[1:0];
        end
        for (int w = 0; w < NWAYS; w++)
            if (m_valid[base+w] && m_rrpv[base+w] == dipr_pkg::RRPV_MAX) return 4'(w);
        return 4'd0;
    endfunction

    function automatic answer_t policy_predict(access_t a);
        answer_t ans;
        int s;
        int slot;
        bit due;
        bit lip;
        logic [63:0] d;
        logic [1:0] rr;
        s = a.set_index % NSETS;
        slot = s * NWAYS + (a.way % NWAYS);
        ans.victim_way = 4'd0;
        ans.typed = 0;
        ans.typed_way = 4'd0;
        ans.typed_outcome = 3'd0;
        if (a.func == dipr_pkg::FUNC_QUERY)
        begin
            ans.victim_way = choose_victim(s * NWAYS, m_stream[s] >= m_stream_th);
            ans.outcome = dipr_pkg::OUT_QUERY;
            return ans;
        end
        m_decay = m_decay + 32'd1;
        due = m_decay >= m_period;
        if (due) m_decay = 32'd0;
        if (m_last[s] != 0)
        begin
            d = a.address - m_last[s];
            if (d >= 1 && d < {48'd0, m_stride})
            begin
                if (m_stream[s] < dipr_pkg::CNT_MAX) m_stream[s]++;
            end
            else if (m_stream[s] > 0)
                m_stream[s]--;
        end
        m_last[s] = a.address;
        if (a.hit)
        begin
            m_dead[slot] = 2'd0;
            m_rrpv[slot] = 2'd0;
            m_valid[slot] = 1;
            ans.outcome = dipr_pkg::OUT_HIT;
            return ans;
        end
        if (m_valid[slot] && m_dead[slot] < dipr_pkg::CNT_MAX) m_dead[slot]++;
        if (m_stream[s] >= m_stream_th || m_dead[slot] >= m_dead_th)
        begin
            m_valid[slot] = 0;
            m_rrpv[slot] = dipr_pkg::RRPV_MAX;
            m_dead[slot] = 2'd0;
            ans.outcome = dipr_pkg::OUT_BYPASS;
            return ans;
        end
        if (m_kind[s] == dipr_pkg::KIND_LIP) lip = 1;
        else if (m_kind[s] == dipr_pkg::KIND_BIP) lip = 0;
        else lip = m_sel < SEL_HALF;
        rr = dipr_pkg::RRPV_MAX;
        if (!lip)
        begin
            if (m_bim == 0) rr = 2'd0;
            m_bim = m_bim + 5'd1;
        end
        m_valid[slot] = 1;
        m_dead[slot] = 2'd0;
        m_rrpv[slot] = rr;
        if (m_kind[s] == dipr_pkg::KIND_LIP && m_sel < SEL_MAX) m_sel++;
        else if (m_kind[s] == dipr_pkg::KIND_BIP && m_sel > 0) m_sel--;
        if (due)
            for (int i = 0; i < NSETS*NWAYS; i++)
                if (m_dead[i] > 0) m_dead[i]--;
        ans.outcome = (rr == 0) ? dipr_pkg::OUT_NEAR : dipr_pkg::OUT_DISTANT;
        return ans;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("[dip_rrip_stream_dead_bypass_policy_core] ERROR");
        $finish;
    end

    // response side
    initial
    begin
        answer_t e;
        rsp.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                    report("unexpected response", rsp.outcome, -1);
                else
                begin
                    e = answer_q.pop_front();
                    if (rsp.victim_way !== e.victim_way)
                        report("victim_way", rsp.victim_way, e.victim_way);
                    if (rsp.outcome !== e.outcome)
                        report("outcome", rsp.outcome, e.outcome);
                    if (e.typed && rsp.victim_way !== e.typed_way)
                        report("victim_way vs table", rsp.victim_way, e.typed_way);
                    if (e.typed && rsp.outcome !== e.typed_outcome)
                        report("outcome vs table", rsp.outcome, e.typed_outcome);
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_request(access_t a, bit typed, logic [3:0] tw, logic [2:0] to);
        answer_t ans;
        if ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req.valid <= 1;
        req.func <= a.func;
        req.set_index <= a.set_index;
        req.way <= a.way;
        req.address <= a.address;
        req.hit <= a.hit;
        do @(posedge clk); while (!req.ready);
        ans = policy_predict(a);
        ans.typed = typed;
        ans.typed_way = tw;
        ans.typed_outcome = to;
        answer_q.push_back(ans);
    endtask

    task automatic write_register(logic [dipr_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dipr_pkg::CFG_W-1:0] data);
        req.valid <= 0;
        while (answer_q.size() != 0) @(posedge clk);
        // an inserting update may still be sweeping dead counters
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            dipr_pkg::CFG_STREAM_TH: m_stream_th = data[1:0];
            dipr_pkg::CFG_DEAD_TH:   m_dead_th = data[1:0];
            dipr_pkg::CFG_STRIDE:    m_stride = data[15:0];
            default:                 m_period = data;
        endcase
    endtask

    function automatic row_t acc_row(logic f, int s, int w, logic [63:0] ad, logic h,
                                     bit typed = 0, logic [3:0] tw = 0, logic [2:0] to = 0);
        row_t r;
        r.is_cfg = 0;
        r.idx = '0;
        r.data = '0;
        r.acc = {f, s[10:0], w[3:0], ad, h};
        r.typed = typed;
        r.typed_way = tw;
        r.typed_outcome = to;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [dipr_pkg::CFG_IDX_W-1:0] idx,
                                     logic [dipr_pkg::CFG_W-1:0] data);
        row_t r;
        r = acc_row(dipr_pkg::FUNC_QUERY, 0, 0, 0, 0);
        r.is_cfg = 1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic access_t random_access();
        access_t a;
        int pick;
        int s;
        pick = $urandom_range(9);
        case (pick)
            0: s = 0;
            1: s = dipr_pkg::LEAD_BIP_ADD;
            2: s = dipr_pkg::LEAD_LIP_MUL;
            3: s = dipr_pkg::LEAD_BIP_MUL + dipr_pkg::LEAD_BIP_ADD;
            4, 5: s = $urandom_range(5, 7);
            6: s = NSETS - 1;
            default: s = $urandom_range(NSETS - 1);
        endcase
        a.func = ($urandom_range(99) < 30) ? dipr_pkg::FUNC_QUERY : dipr_pkg::FUNC_UPDATE;
        a.set_index = 11'(s);
        a.way = ($urandom_range(99) < 60) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        a.hit = $urandom_range(99) < 35;
        if ($urandom_range(99) < 70)
            a.address = m_last[s] + 64'($urandom_range(1, 200));
        else
            a.address = {$urandom, $urandom};
        return a;
    endfunction

    row_t plan[$];

    initial
    begin
        row_t r;
        policy_reset();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 0;
        req.func = 0;
        req.set_index = '0;
        req.way = '0;
        req.address = '0;
        req.hit = 0;

        // empty set, hits, misses, leaders, streaming, extremes
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 5, 0, 0, 0, 1, 0, dipr_pkg::OUT_QUERY));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 5, 15, 0, 1, 1, 0, dipr_pkg::OUT_HIT));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 5, 0, '1, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 5, 9, '1, 1));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 0, 3, 64'h40, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, dipr_pkg::LEAD_BIP_ADD, 7, 64'h80, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 2047, 1, 64'h100, 1, 1, 0,
                               dipr_pkg::OUT_HIT));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 2047, 1, 64'h140, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 2047, 2, 64'h180, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 2047, 3, 64'h1c0, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 2047, 0, 0, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 2047, 1, 0, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 2047, 0, 0, 0));
        plan.push_back(cfg_row(dipr_pkg::CFG_DEAD_TH, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 9, 0, 64'h1000, 0, 1, 0,
                               dipr_pkg::OUT_BYPASS));
        plan.push_back(cfg_row(dipr_pkg::CFG_DEAD_TH, 3));
        plan.push_back(cfg_row(dipr_pkg::CFG_STREAM_TH, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 10, 4, 64'h2000, 0, 1, 0,
                               dipr_pkg::OUT_BYPASS));
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 5, 0, 0, 0));
        plan.push_back(cfg_row(dipr_pkg::CFG_STREAM_TH, 3));
        plan.push_back(cfg_row(dipr_pkg::CFG_STRIDE, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 5, 6, '1, 0));
        plan.push_back(cfg_row(dipr_pkg::CFG_STRIDE, 16'hFFFF));
        plan.push_back(cfg_row(dipr_pkg::CFG_DECAY, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 6, 2, 64'h10, 1));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 6, 2, 64'h20, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 6, 3, 64'h30, 0));
        plan.push_back(cfg_row(dipr_pkg::CFG_DECAY, 32'hFFFF_FFFF));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 7, 2, 64'h8000_0000_0000_0000, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 7, 2, 64'h10, 0));
        plan.push_back(acc_row(dipr_pkg::FUNC_QUERY, 7, 0, 0, 0));
        // period below the running count
        plan.push_back(cfg_row(dipr_pkg::CFG_DECAY, 1));
        plan.push_back(acc_row(dipr_pkg::FUNC_UPDATE, 7, 5, 64'h50, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1;

        foreach (plan[i])
        begin
            r = plan[i];
            if (r.is_cfg)
                write_register(r.idx, r.data);
            else
                send_request(r.acc, r.typed, r.typed_way, r.typed_outcome);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 17 : (phase == 1) ? 74 : 0;
            recv_idle = (phase == 0) ? 74 : (phase == 1) ? 17 : 0;
            for (int sub = 0; sub < 2; sub++)
            begin
                write_register(dipr_pkg::CFG_STREAM_TH, $urandom_range(1, 3));
                write_register(dipr_pkg::CFG_DEAD_TH, $urandom_range(1, 3));
                case ($urandom_range(3))
                    0: write_register(dipr_pkg::CFG_STRIDE, $urandom_range(1, 65535));
                    1: write_register(dipr_pkg::CFG_STRIDE, 16'hFFFF);
                    2: write_register(dipr_pkg::CFG_STRIDE, dipr_pkg::STRIDE_RST);
                    default: write_register(dipr_pkg::CFG_STRIDE, $urandom_range(64, 512));
                endcase
                case ($urandom_range(3))
                    0: write_register(dipr_pkg::CFG_DECAY, $urandom_range(20, 80));
                    1: write_register(dipr_pkg::CFG_DECAY, 32'hFFFF_FFFF);
                    2: write_register(dipr_pkg::CFG_DECAY, dipr_pkg::DECAY_RST);
                    default: write_register(dipr_pkg::CFG_DECAY, $urandom_range(20, 300));
                endcase
                repeat (315) send_request(random_access(), 0, 0, 0);
            end
        end

        req.valid <= 0;
        while (answer_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[dip_rrip_stream_dead_bypass_policy_core] OK");
        else
            $display("[dip_rrip_stream_dead_bypass_policy_core] ERROR");
        $finish;
    end

endmodule
